// ===== rtl/dtli_pkg.sv =====
// ----------------------------------------------------------------------------
// dtli_pkg
// Shared types, codes and fixed-point helpers of the dual table interpolator.
// ----------------------------------------------------------------------------
package dtli_pkg;

   localparam int SAT_W      = 18;
   localparam int Q_W        = 32;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DIV_NUM_W  = 53;
   localparam int DIV_DEN_W  = 18;
   localparam int DIV_Q_W    = 54;
   localparam int WIDE_W     = 56;
   localparam int SLOPE_SHIFT = 15;
   localparam int GRAD_SHIFT  = 16;

   localparam logic [1:0] MODE_EVAL  = 2'd0;
   localparam logic [1:0] MODE_WATER = 2'd1;
   localparam logic [1:0] MODE_GAS   = 2'd2;

   localparam logic [1:0] POLICY_ERROR = 2'd0;
   localparam logic [1:0] POLICY_CLAMP = 2'd1;

   localparam logic [1:0] STATUS_IN    = 2'd0;
   localparam logic [1:0] STATUS_BELOW = 2'd1;
   localparam logic [1:0] STATUS_ABOVE = 2'd2;

   localparam logic [1:0] CSR_POLICY      = 2'd0;
   localparam logic [1:0] CSR_WATER_COUNT = 2'd1;
   localparam logic [1:0] CSR_GAS_COUNT   = 2'd2;

   localparam logic signed [WIDE_W-1:0] Q_MAX_WIDE = 56'sd2147483647;
   localparam logic signed [WIDE_W-1:0] Q_MIN_WIDE = -56'sd2147483648;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DECIDE,
      ST_LO_RD,
      ST_LO_CAP,
      ST_HI_RD,
      ST_HI_CAP,
      ST_CALC,
      ST_MUL_VAL,
      ST_DIV_VAL,
      ST_DIV_SLOPE,
      ST_GRAD_MUL,
      ST_GRAD_CAP,
      ST_PHASE_DONE,
      ST_RESULT
   } state_type;

   // optional negate, then clip to the signed 32-bit range
   function automatic logic signed [Q_W-1:0] sat_q32(input logic signed [WIDE_W-1:0] x,
                                                     input logic neg);
      logic signed [WIDE_W-1:0] v;
      v = neg ? -x : x;
      if (v > Q_MAX_WIDE) begin
         return Q_MAX_WIDE[Q_W-1:0];
      end else if (v < Q_MIN_WIDE) begin
         return Q_MIN_WIDE[Q_W-1:0];
      end
      return v[Q_W-1:0];
   endfunction

   // divide by 2^16, round to nearest, ties away from zero
   function automatic logic signed [WIDE_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] q;
      mag = p[PROD_W-1] ? unsigned'(-p) : unsigned'(p);
      q   = (mag + (PROD_W'(1) << (GRAD_SHIFT - 1))) >> GRAD_SHIFT;
      return p[PROD_W-1] ? -signed'(q[WIDE_W-1:0]) : signed'(q[WIDE_W-1:0]);
   endfunction

endpackage

// ===== rtl/dtli_table.sv =====
// ----------------------------------------------------------------------------
// dtli_table
// One breakpoint/pressure table: single write port, registered read port.
// ----------------------------------------------------------------------------
module dtli_table #(
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [$clog2(DEPTH)-1:0]              wr_addr,
   input  logic signed [dtli_pkg::SAT_W-1:0]     wr_point,
   input  logic signed [dtli_pkg::Q_W-1:0]       wr_value,
   input  logic [$clog2(DEPTH)-1:0]              rd_addr,
   output logic signed [dtli_pkg::SAT_W-1:0]     rd_point,
   output logic signed [dtli_pkg::Q_W-1:0]       rd_value
);
   import dtli_pkg::*;

   logic [SAT_W+Q_W-1:0] mem [DEPTH];
   logic [SAT_W+Q_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_point, wr_value};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_point = signed'(rd_data_ff[SAT_W+Q_W-1:Q_W]);
   assign rd_value = signed'(rd_data_ff[Q_W-1:0]);

endmodule

// ===== rtl/dtli_alu.sv =====
// ----------------------------------------------------------------------------
// dtli_alu
// Shared arithmetic: registered signed multiplier and a bit-serial rounding
// divider (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module dtli_alu (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic signed [dtli_pkg::MUL_W-1:0]       mul_a,
   input  logic signed [dtli_pkg::MUL_W-1:0]       mul_b,
   output logic signed [dtli_pkg::PROD_W-1:0]      mul_p,
   input  logic                                    div_go,
   input  logic signed [dtli_pkg::DIV_NUM_W-1:0]   div_num,
   input  logic [dtli_pkg::DIV_DEN_W-1:0]          div_den,
   output logic                                    div_done,
   output logic signed [dtli_pkg::DIV_Q_W:0]       div_q
);
   import dtli_pkg::*;

   localparam int CNT_W = $clog2(DIV_Q_W);

   logic signed [PROD_W-1:0] prod_ff;
   logic [DIV_Q_W-1:0]       quo_ff;
   logic [DIV_DEN_W-1:0]     rem_ff;
   logic [DIV_DEN_W-1:0]     den_ff;
   logic                     neg_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     run_ff;
   logic                     done_ff;

   logic [DIV_NUM_W-1:0]     num_mag;
   logic [DIV_Q_W-1:0]       dividend;
   logic [DIV_DEN_W:0]       rem_sh;
   logic                     ge;
   logic [DIV_DEN_W:0]       rem_sub;

   always_comb begin
      num_mag  = div_num[DIV_NUM_W-1] ? unsigned'(-div_num) : unsigned'(div_num);
      dividend = DIV_Q_W'(num_mag) + DIV_Q_W'(div_den >> 1);
      rem_sh   = {rem_ff, quo_ff[DIV_Q_W-1]};
      ge       = rem_sh >= {1'b0, den_ff};
      rem_sub  = rem_sh - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (div_go) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= div_den;
         neg_ff <= div_num[DIV_NUM_W-1];
      end else if (run_ff) begin
         quo_ff <= {quo_ff[DIV_Q_W-2:0], ge};
         rem_ff <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_go) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(DIV_Q_W - 1);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign mul_p    = prod_ff;
   assign div_done = done_ff;
   assign div_q    = neg_ff ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});

endmodule

// ===== rtl/dual_table_linear_interp_gradient.sv =====
// ----------------------------------------------------------------------------
// dual_table_linear_interp_gradient
// Each evaluation scans both tables and, for each table that it interpolates,
// runs the bit-serial divider twice (value and slope) before rsp_strobe. A new
// evaluate beat or table write is accepted only while idle. Synchronous reset
// returns control to idle, the policy to error and both counts to 2.
// Results are presented for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module dual_table_linear_interp_gradient #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_mode,
   input  logic signed [17:0]                    req_water_saturation,
   input  logic signed [31:0]                    req_water_grad_x,
   input  logic signed [31:0]                    req_water_grad_y,
   input  logic signed [31:0]                    req_water_grad_z,
   input  logic signed [17:0]                    req_gas_saturation,
   input  logic signed [31:0]                    req_gas_grad_x,
   input  logic signed [31:0]                    req_gas_grad_y,
   input  logic signed [31:0]                    req_gas_grad_z,
   input  logic [3:0]                            req_entry_index,
   input  logic signed [17:0]                    req_entry_point,
   input  logic signed [31:0]                    req_entry_value,
   output logic                                  rsp_strobe,
   output logic signed [31:0]                    rsp_water_pressure_diff,
   output logic signed [31:0]                    rsp_water_out_grad_x,
   output logic signed [31:0]                    rsp_water_out_grad_y,
   output logic signed [31:0]                    rsp_water_out_grad_z,
   output logic signed [31:0]                    rsp_gas_pressure_diff,
   output logic signed [31:0]                    rsp_gas_out_grad_x,
   output logic signed [31:0]                    rsp_gas_out_grad_y,
   output logic signed [31:0]                    rsp_gas_out_grad_z,
   output logic [1:0]                            rsp_water_range_status,
   output logic [1:0]                            rsp_gas_range_status,
   input  logic                                  csr_write_enable,
   input  logic [1:0]                            csr_index,
   input  logic [4:0]                            csr_write_data
);
   import dtli_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   state_type state_ff, state_in;

   logic [1:0] policy_ff;
   logic [4:0] wcnt_ff;
   logic [4:0] gcnt_ff;

   logic                    phase_ff;
   logic [AW-1:0]           idx_ff;
   logic [AW-1:0]           lo_ff;
   logic [1:0]              status_ff;
   logic [1:0]              k_ff;
   logic signed [SAT_W-1:0] s_ff [2];
   logic signed [Q_W-1:0]   g_ff [2][3];
   logic signed [SAT_W-1:0] bp_lo_ff;
   logic signed [SAT_W-1:0] bp_hi_ff;
   logic signed [Q_W-1:0]   pv_lo_ff;
   logic signed [Q_W-1:0]   pv_hi_ff;
   logic signed [Q_W-1:0]   slope_ff;
   logic signed [Q_W-1:0]   press_ff [2];
   logic signed [Q_W-1:0]   grad_ff [2][3];
   logic [1:0]              stat_ff [2];

   logic                    accept;
   logic                    idx_ok;
   logic                    water_we;
   logic                    gas_we;
   logic [AW-1:0]           wr_addr;
   logic signed [SAT_W-1:0] w_point, g_point, rd_point;
   logic signed [Q_W-1:0]   w_value, g_value, rd_value;
   logic [4:0]              cnt_sel;
   logic [31:0]             eff_cnt;
   logic [AW-1:0]           last_idx;
   logic signed [SAT_W-1:0] cur_s;
   logic signed [SAT_W:0]   dp;
   logic signed [Q_W:0]     dv;
   logic signed [SAT_W:0]   ds;
   logic                    oor;
   logic                    is_error;
   logic                    is_clamp;
   logic                    neg;

   logic signed [MUL_W-1:0]     mul_a, mul_b;
   logic signed [PROD_W-1:0]    mul_p;
   logic                        div_go;
   logic signed [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0]        div_den;
   logic                        div_done;
   logic signed [DIV_Q_W:0]     div_q;

   // table write beats complete in the accept cycle
   always_comb begin
      accept   = start && !busy;
      idx_ok   = 32'(req_entry_index) < TABLE_DEPTH;
      wr_addr  = AW'(req_entry_index);
      water_we = accept && (req_mode == MODE_WATER) && idx_ok;
      gas_we   = accept && (req_mode == MODE_GAS) && idx_ok;
   end

   dtli_table #(.DEPTH(TABLE_DEPTH)) u_water (
      .clock    (clock),
      .wr_en    (water_we),
      .wr_addr  (wr_addr),
      .wr_point (req_entry_point),
      .wr_value (req_entry_value),
      .rd_addr  (idx_ff),
      .rd_point (w_point),
      .rd_value (w_value)
   );

   dtli_table #(.DEPTH(TABLE_DEPTH)) u_gas (
      .clock    (clock),
      .wr_en    (gas_we),
      .wr_addr  (wr_addr),
      .wr_point (req_entry_point),
      .wr_value (req_entry_value),
      .rd_addr  (idx_ff),
      .rd_point (g_point),
      .rd_value (g_value)
   );

   dtli_alu u_alu (
      .clock    (clock),
      .reset    (reset),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_p    (mul_p),
      .div_go   (div_go),
      .div_num  (div_num),
      .div_den  (div_den),
      .div_done (div_done),
      .div_q    (div_q)
   );

   always_comb begin
      rd_point = phase_ff ? g_point : w_point;
      rd_value = phase_ff ? g_value : w_value;
      cnt_sel  = phase_ff ? gcnt_ff : wcnt_ff;
      if (32'(cnt_sel) < 32'd2) begin
         eff_cnt = 32'd2;
      end else if (32'(cnt_sel) > TABLE_DEPTH) begin
         eff_cnt = 32'(TABLE_DEPTH);
      end else begin
         eff_cnt = 32'(cnt_sel);
      end
      last_idx = AW'(eff_cnt - 32'd1);
      cur_s    = s_ff[phase_ff];
      dp       = (SAT_W+1)'(bp_hi_ff) - (SAT_W+1)'(bp_lo_ff);
      dv       = (Q_W+1)'(pv_hi_ff) - (Q_W+1)'(pv_lo_ff);
      ds       = (SAT_W+1)'(cur_s) - (SAT_W+1)'(bp_lo_ff);
      oor      = status_ff != STATUS_IN;
      is_error = oor && (policy_ff == POLICY_ERROR);
      is_clamp = oor && (policy_ff == POLICY_CLAMP);
      neg      = !phase_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_EVAL) state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD:   state_in = ST_SCAN_CMP;
         ST_SCAN_CMP:  state_in = (idx_ff == last_idx) ? ST_DECIDE : ST_SCAN_RD;
         ST_DECIDE:    state_in = is_error ? ST_PHASE_DONE : ST_LO_RD;
         ST_LO_RD:     state_in = ST_LO_CAP;
         ST_LO_CAP:    state_in = is_clamp ? ST_PHASE_DONE : ST_HI_RD;
         ST_HI_RD:     state_in = ST_HI_CAP;
         ST_HI_CAP:    state_in = ST_CALC;
         ST_CALC:      state_in = (dp <= 0) ? ST_PHASE_DONE : ST_MUL_VAL;
         ST_MUL_VAL:   state_in = ST_DIV_VAL;
         ST_DIV_VAL: begin
            if (div_done) state_in = ST_DIV_SLOPE;
         end
         ST_DIV_SLOPE: begin
            if (div_done) state_in = ST_GRAD_MUL;
         end
         ST_GRAD_MUL:  state_in = ST_GRAD_CAP;
         ST_GRAD_CAP:  state_in = (k_ff == 2'd2) ? ST_PHASE_DONE : ST_GRAD_MUL;
         ST_PHASE_DONE: state_in = phase_ff ? ST_RESULT : ST_SCAN_RD;
         ST_RESULT:    state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs and shared unit control
   always_comb begin
      busy       = state_ff != ST_IDLE;
      rsp_strobe = state_ff == ST_RESULT;
      mul_a      = MUL_W'(dv);
      mul_b      = MUL_W'(ds);
      div_go     = 1'b0;
      div_num    = DIV_NUM_W'(mul_p);
      div_den    = dp[DIV_DEN_W-1:0];
      unique case (state_ff)
         ST_MUL_VAL: begin
            div_go = 1'b1;
         end
         ST_DIV_VAL: begin
            div_go  = div_done;
            div_num = DIV_NUM_W'(dv) <<< SLOPE_SHIFT;
         end
         ST_GRAD_MUL: begin
            mul_a = MUL_W'(slope_ff);
            mul_b = MUL_W'(g_ff[phase_ff][k_ff]);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         policy_ff <= POLICY_ERROR;
         wcnt_ff   <= 5'd2;
         gcnt_ff   <= 5'd2;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_POLICY:      policy_ff <= csr_write_data[1:0];
               CSR_WATER_COUNT: wcnt_ff   <= csr_write_data;
               CSR_GAS_COUNT:   gcnt_ff   <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_EVAL) begin
               s_ff[0]    <= req_water_saturation;
               s_ff[1]    <= req_gas_saturation;
               g_ff[0][0] <= req_water_grad_x;
               g_ff[0][1] <= req_water_grad_y;
               g_ff[0][2] <= req_water_grad_z;
               g_ff[1][0] <= req_gas_grad_x;
               g_ff[1][1] <= req_gas_grad_y;
               g_ff[1][2] <= req_gas_grad_z;
               phase_ff   <= 1'b0;
               idx_ff     <= '0;
               lo_ff      <= '0;
               status_ff  <= STATUS_IN;
            end
         end
         ST_SCAN_CMP: begin
            if (idx_ff == '0 && cur_s < rd_point) status_ff <= STATUS_BELOW;
            if (idx_ff != last_idx && rd_point <= cur_s) lo_ff <= idx_ff;
            if (idx_ff == last_idx && status_ff == STATUS_IN && cur_s > rd_point) begin
               status_ff <= STATUS_ABOVE;
            end
            if (idx_ff != last_idx) idx_ff <= idx_ff + 1'b1;
         end
         ST_DECIDE: begin
            if (is_error) begin
               press_ff[phase_ff] <= '0;
               for (int i = 0; i < 3; i++) grad_ff[phase_ff][i] <= '0;
            end else if (is_clamp) begin
               idx_ff <= (status_ff == STATUS_BELOW) ? '0 : last_idx;
            end else begin
               idx_ff <= lo_ff;
            end
         end
         ST_LO_CAP: begin
            bp_lo_ff <= rd_point;
            pv_lo_ff <= rd_value;
            if (is_clamp) begin
               press_ff[phase_ff] <= sat_q32(WIDE_W'(rd_value), neg);
               for (int i = 0; i < 3; i++) grad_ff[phase_ff][i] <= '0;
            end else begin
               idx_ff <= lo_ff + 1'b1;
            end
         end
         ST_HI_CAP: begin
            bp_hi_ff <= rd_point;
            pv_hi_ff <= rd_value;
         end
         ST_CALC: begin
            if (dp <= 0) begin
               press_ff[phase_ff] <= sat_q32(WIDE_W'(pv_lo_ff), neg);
               for (int i = 0; i < 3; i++) grad_ff[phase_ff][i] <= '0;
            end
         end
         ST_DIV_VAL: begin
            if (div_done) begin
               press_ff[phase_ff] <= sat_q32(WIDE_W'(pv_lo_ff) + WIDE_W'(div_q), neg);
            end
         end
         ST_DIV_SLOPE: begin
            if (div_done) begin
               slope_ff <= sat_q32(WIDE_W'(div_q), 1'b0);
               k_ff     <= 2'd0;
            end
         end
         ST_GRAD_CAP: begin
            grad_ff[phase_ff][k_ff] <= sat_q32(round_q16(mul_p), neg);
            k_ff <= k_ff + 1'b1;
         end
         ST_PHASE_DONE: begin
            stat_ff[phase_ff] <= status_ff;
            if (!phase_ff) begin
               phase_ff  <= 1'b1;
               idx_ff    <= '0;
               lo_ff     <= '0;
               status_ff <= STATUS_IN;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_water_pressure_diff = press_ff[0];
   assign rsp_water_out_grad_x    = grad_ff[0][0];
   assign rsp_water_out_grad_y    = grad_ff[0][1];
   assign rsp_water_out_grad_z    = grad_ff[0][2];
   assign rsp_gas_pressure_diff   = press_ff[1];
   assign rsp_gas_out_grad_x      = grad_ff[1][0];
   assign rsp_gas_out_grad_y      = grad_ff[1][1];
   assign rsp_gas_out_grad_z      = grad_ff[1][2];
   assign rsp_water_range_status  = stat_ff[0];
   assign rsp_gas_range_status    = stat_ff[1];

endmodule
